// File: rtl/core/capability_slot_grant_check_assert.svh
// assertion macros used by the capability slot rtl
`ifndef CAPABILITY_SLOT_GRANT_CHECK_ASSERT_SVH
`define CAPABILITY_SLOT_GRANT_CHECK_ASSERT_SVH

`ifndef SYNTH

`define CSGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CSGC_ASSERT_NEVER(lbl, expr, msg) \
  `CSGC_ASSERT(lbl, !(expr), msg)

`else

`define CSGC_ASSERT(lbl, prop, msg)

`define CSGC_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: rtl/core/csgc_pkg.sv
package csgc_pkg;

  localparam int KIND_W   = 8;
  localparam int RIGHTS_W = 32;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int KIND_BITS_DEF   = 8;
  localparam int SLOTS_RESET     = 16;

  localparam logic OP_GRANT = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [RIGHTS_W-1:0] rights;
  } csgc_entry_t;

  function automatic int idx_w(int slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

  // stored kind width: the incoming field never carries more than KIND_W bits
  function automatic int kind_w(int kind_bits);
    return (kind_bits < KIND_W) ? kind_bits : KIND_W;
  endfunction

endpackage

// File: rtl/core/capability_slot_grant_check.sv
// channel | direction | ports                                | handshake
// in      | input     | in_operation, in_kind, in_rights     | in_valid / in_ready
// out     | output    | out_status, out_slot                 | out_valid / out_ready
// cfg     | input     | cfg_wr_data (slots_in_use)           | cfg_wr_en, no wait
//
// a new item is taken only in idle, after the last result; the scan stops at the slot
// that matches, or after n slots if none does (n = slots in use, at most TABLE_SLOTS)
// the scan reads one slot a cycle through the table's single read port
// reset is synchronous, active low; it empties every slot and sets the configured slot count to 16
// a waiting result holds the block in its final state until out_ready
module capability_slot_grant_check
  import csgc_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KIND_BITS   = KIND_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [RIGHTS_W-1:0] in_rights,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_status,
  output logic [SLOT_W-1:0]   out_slot,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data
);

  localparam int IW    = idx_w(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int KW    = kind_w(KIND_BITS);
  localparam logic [KIND_W-1:0] KIND_MASK = KIND_W'((64'd1 << KW) - 64'd1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [RIGHTS_W-1:0] rights_r, rights_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic                res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [CFG_W-1:0]    cfg_slots_r, cfg_slots_nxt;

  logic [CNT_W-1:0] n_clamp;
  logic             rd_en;
  logic             hit;
  logic             scan_hit;
  logic             tbl_wr_en;
  csgc_entry_t      tbl_rd_data;
  csgc_entry_t      tbl_wr_data;

  csgc_table #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KIND_BITS   (KIND_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (pend_idx_r),
    .wr_data (tbl_wr_data)
  );

  always_comb begin
    if (NW'(cfg_slots_r) > NW'(TABLE_SLOTS)) begin
      n_clamp = CNT_W'(TABLE_SLOTS);
    end else begin
      n_clamp = CNT_W'(cfg_slots_r);
    end
  end

  // the one compare unit: empty slot for a grant, kind and rights cover for a check
  always_comb begin
    if (op_r == OP_GRANT) begin
      hit = (tbl_rd_data.kind == '0);
    end else begin
      hit = (tbl_rd_data.kind == kind_r) && ((tbl_rd_data.rights & rights_r) == rights_r);
    end
  end

  assign scan_hit    = pend_r && hit;
  assign rd_en       = (state_r == S_SCAN) && !scan_hit && (cnt_r < n_r);
  assign tbl_wr_en   = (state_r == S_SCAN) && scan_hit && (op_r == OP_GRANT);
  assign tbl_wr_data = '{kind: kind_r, rights: rights_r};

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    kind_nxt       = kind_r;
    rights_nxt     = rights_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    cfg_slots_nxt  = cfg_slots_r;

    if (cfg_wr_en) begin
      cfg_slots_nxt = cfg_wr_data;
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          kind_nxt   = in_kind & KIND_MASK;
          rights_nxt = in_rights;
          n_nxt      = n_clamp;
          cnt_nxt    = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // read of slot cnt goes out while the previous slot is compared
        pend_nxt     = rd_en;
        pend_idx_nxt = cnt_r[IW-1:0];
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (scan_hit) begin
          res_status_nxt = STATUS_OK;
          res_slot_nxt   = (op_r == OP_GRANT) ? SLOT_W'(pend_idx_r) : '0;
          state_nxt      = S_DONE;
        end else if (!rd_en) begin
          res_status_nxt = STATUS_FAIL;
          res_slot_nxt   = '0;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_slots_r <= CFG_W'(SLOTS_RESET);
      cnt_r       <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_slots_r <= cfg_slots_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    kind_r       <= kind_nxt;
    rights_r     <= rights_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

`include "capability_slot_grant_check_assert.svh"

  `CSGC_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE, "result word not from final state")
  `CSGC_ASSERT(a_cnt_bound, state_r == S_SCAN |-> cnt_r <= n_r, "scan ran past slots in use")
  `CSGC_ASSERT(a_pend_in_range, pend_r |-> CNT_W'(pend_idx_r) < n_r, "compared slot out of range")
  `CSGC_ASSERT_NEVER(a_fail_slot_zero, out_valid_r && out_status_r == STATUS_FAIL && out_slot_r != '0, "failed word carries a slot")

endmodule

// File: rtl/core/csgc_table.sv
module csgc_table
  import csgc_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KIND_BITS   = KIND_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [idx_w(TABLE_SLOTS)-1:0]  rd_addr,
  output csgc_entry_t                    rd_data,
  input  logic                           wr_en,
  input  logic [idx_w(TABLE_SLOTS)-1:0]  wr_addr,
  input  csgc_entry_t                    wr_data
);

  localparam int KW = kind_w(KIND_BITS);

  logic [KW-1:0]       kind_mem   [TABLE_SLOTS];
  logic [RIGHTS_W-1:0] rights_mem [TABLE_SLOTS];

  logic [TABLE_SLOTS-1:0] slot_vld_r;
  logic [KW-1:0]          rd_kind_r;
  logic [RIGHTS_W-1:0]    rd_rights_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind_mem[wr_addr]   <= wr_data.kind[KW-1:0];
      rights_mem[wr_addr] <= wr_data.rights;
    end
    if (rd_en) begin
      rd_kind_r   <= kind_mem[rd_addr];
      rd_rights_r <= rights_mem[rd_addr];
    end
  end

  // a slot never written reads as empty with no rights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= slot_vld_r[rd_addr];
      end
    end
  end

  assign rd_data.kind   = rd_vld_r ? KIND_W'(rd_kind_r) : '0;
  assign rd_data.rights = rd_vld_r ? rd_rights_r : '0;

endmodule
